// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex LMS equalizer package
// Sizes, codes and the control types shared by the equalizer modules.
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam int MAX_TAPS = 32;
   localparam int MAX_POLS = 2;
   localparam int TAP_W    = $clog2(MAX_TAPS);
   localparam int POL_W    = 1;
   localparam int ADDR_W   = POL_W + TAP_W;
   localparam int DEPTH    = MAX_POLS * MAX_TAPS;

   localparam int SMP_W    = 16;
   localparam int COEF_W   = 24;
   localparam int OUT_W    = 20;
   localparam int STEP_W   = 16;
   localparam int PROD_W   = COEF_W + SMP_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int UPD_W    = 2 * SMP_W + 1;
   localparam int ACC_W    = SUM_W + TAP_W + POL_W + 1;
   localparam int DLT_W    = STEP_W + 1 + UPD_W;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_FILTER = 2'd1,
      OP_UPDATE = 2'd2,
      OP_WRTAP  = 2'd3
   } cle_op_type;

   typedef enum logic [1:0] {
      REG_TAPS = 2'd0,
      REG_POLS = 2'd1,
      REG_STEP = 2'd2
   } cle_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } cle_state_type;

   typedef struct packed {
      logic vld;
      logic upd;
      logic clr;
   } cle_mac_ctrl_type;

   typedef struct packed {
      logic s1_vld;
      logic s2_vld;
      logic s3_vld;
   } cle_mac_stat_type;

endpackage

// ===== rtl/cle_mac.sv =====
// ----------------------------------------------------------------------------
// Complex multiply-accumulate unit
// Three-stage shared unit: four products, their complex combination, then
// either accumulation for the filter output or scaling by the step size.
// ----------------------------------------------------------------------------
module cle_mac import cle_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cle_mac_ctrl_type         ctrl,
   input  logic [STEP_W-1:0]        mu,
   input  logic signed [COEF_W-1:0] a_re,
   input  logic signed [COEF_W-1:0] a_im,
   input  logic signed [SMP_W-1:0]  x_re,
   input  logic signed [SMP_W-1:0]  x_im,
   output cle_mac_stat_type         stat,
   output logic signed [ACC_W-1:0]  acc_re,
   output logic signed [ACC_W-1:0]  acc_im,
   output logic signed [DLT_W-1:0]  dlt_re,
   output logic signed [DLT_W-1:0]  dlt_im
);

   logic                     vld1_ff, vld2_ff, vld3_ff;
   logic signed [PROD_W-1:0] m0_ff, m1_ff, m2_ff, m3_ff;
   logic signed [SUM_W-1:0]  s_re_ff, s_im_ff;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_im_ff;
   logic signed [DLT_W-1:0]  dlt_re_ff, dlt_im_ff;
   logic signed [STEP_W:0]   mu_s;

   assign mu_s = $signed({1'b0, mu});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= ctrl.vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      m0_ff <= a_re * x_re;
      m1_ff <= a_im * x_im;
      m2_ff <= a_re * x_im;
      m3_ff <= a_im * x_re;
   end

   // The update error sits in the a inputs, so the conjugate product uses
   // the same four multipliers with different signs.
   always_ff @(posedge clock) begin
      if (ctrl.upd) begin
         s_re_ff <= SUM_W'(m0_ff) + SUM_W'(m1_ff);
         s_im_ff <= SUM_W'(m3_ff) - SUM_W'(m2_ff);
      end else begin
         s_re_ff <= SUM_W'(m0_ff) - SUM_W'(m1_ff);
         s_im_ff <= SUM_W'(m2_ff) + SUM_W'(m3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clr) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (vld2_ff && !ctrl.upd) begin
         acc_re_ff <= acc_re_ff + ACC_W'(s_re_ff);
         acc_im_ff <= acc_im_ff + ACC_W'(s_im_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (vld2_ff && ctrl.upd) begin
         dlt_re_ff <= mu_s * $signed(s_re_ff[UPD_W-1:0]);
         dlt_im_ff <= mu_s * $signed(s_im_ff[UPD_W-1:0]);
      end
   end

   assign stat.s1_vld = vld1_ff;
   assign stat.s2_vld = vld2_ff;
   assign stat.s3_vld = vld3_ff;
   assign acc_re      = acc_re_ff;
   assign acc_im      = acc_im_ff;
   assign dlt_re      = dlt_re_ff;
   assign dlt_im      = dlt_im_ff;

endmodule

// ===== rtl/complex_lms_fir_equaliser_top.sv =====
// ----------------------------------------------------------------------------
// Complex LMS adaptive FIR equalizer
// Up to two polarizations of 32 complex taps; sample push, filter output,
// LMS tap update and direct tap write.
// ----------------------------------------------------------------------------
// A push or tap write is done in the cycle it is accepted. A filter or update item
// walks one complex multiply-accumulate over every tap in use, one tap a cycle:
// after the accept it issues every tap of each polarization in use, drains the
// read stage and the three arithmetic stages, and then sees them empty; a filter
// item then loads its result once the result register is free or being read. No new request is taken until then.
// The sample and tap memories have one read port each, which sets that pace.
// Memory entries are zero after reset through per-entry valid bits, so there
// is no clearing pass.
`include "assert_macros.svh"

module complex_lms_fir_equaliser_top import cle_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tap_index, sample_re, sample_im, err_re, err_im, tap_re, tap_im, zero pad
   input  logic [119:0] req_tdata,
   // op, pol
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_re, out_im
   output logic [39:0]  rsp_tdata,
   // saturated
   output logic         rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic signed [27:0] OUT_MAX = 28'sd524287;
   localparam logic signed [27:0] OUT_MIN = -28'sd524288;
   localparam logic signed [25:0] TAP_MAX = 26'sd8388607;
   localparam logic signed [25:0] TAP_MIN = -26'sd8388608;

   function automatic logic [OUT_W:0] clip_out(input logic signed [27:0] v);
      logic [OUT_W:0] r;
      if (v > OUT_MAX) begin
         r = {1'b1, OUT_MAX[OUT_W-1:0]};
      end else if (v < OUT_MIN) begin
         r = {1'b1, OUT_MIN[OUT_W-1:0]};
      end else begin
         r = {1'b0, v[OUT_W-1:0]};
      end
      return r;
   endfunction

   function automatic logic [COEF_W-1:0] clip_tap(input logic signed [25:0] v);
      logic [COEF_W-1:0] r;
      if (v > TAP_MAX) begin
         r = TAP_MAX[COEF_W-1:0];
      end else if (v < TAP_MIN) begin
         r = TAP_MIN[COEF_W-1:0];
      end else begin
         r = v[COEF_W-1:0];
      end
      return r;
   endfunction

   // Configuration
   logic [5:0]        taps_ff;
   logic [1:0]        pols_ff;
   logic [STEP_W-1:0] step_ff;
   logic [5:0]        nt;
   logic [1:0]        np;
   logic              csr_wr;
   cle_reg_type       csr_reg;

   // Sequencer
   cle_state_type     state_ff, state_in;
   logic [TAP_W-1:0]  j_ff, j_in;
   logic [POL_W-1:0]  k_ff, k_in;
   cle_op_type        op_ff, req_op;
   logic [SMP_W-1:0]  err_re_ff, err_im_ff;
   logic              req_acc, issue, last_issue, rsp_load, pipe_busy;

   // Storage
   logic [2*SMP_W-1:0]  smp_mem [DEPTH];
   logic [2*COEF_W-1:0] tap_mem [DEPTH];
   logic [DEPTH-1:0]    smp_vld_ff, tap_vld_ff;
   logic [TAP_W-1:0]    head_ff [MAX_POLS];
   logic [POL_W-1:0]    head_sel;
   logic [TAP_W-1:0]    head_cur, head_nxt;
   logic [TAP_W-1:0]    slot;
   logic                push_we;
   logic                tap_we;
   logic [ADDR_W-1:0]   tap_waddr;
   logic [2*COEF_W-1:0] tap_wdata;

   // Read stage
   logic                rd_vld_ff;
   logic [ADDR_W-1:0]   rd_addr_ff;
   logic [2*SMP_W-1:0]  smp_rd_ff, smp_eff;
   logic [2*COEF_W-1:0] tap_rd_ff, tap_eff;
   logic                smp_ok_ff, tap_ok_ff;
   logic [2*COEF_W-1:0] tap_p_ff [3];
   logic [ADDR_W-1:0]   addr_p_ff [3];

   // Arithmetic unit
   cle_mac_ctrl_type          mac_ctrl;
   cle_mac_stat_type          mac_stat;
   logic signed [COEF_W-1:0]  mac_a_re, mac_a_im;
   logic signed [ACC_W-1:0]   acc_re, acc_im;
   logic signed [DLT_W-1:0]   dlt_re, dlt_im;
   logic signed [DLT_W-1:0]   rnd_re, rnd_im;
   logic signed [25:0]        new_re, new_im;
   logic                      wb_we;
   logic signed [ACC_W-1:0]   out_rnd_re, out_rnd_im;
   logic [OUT_W:0]            out_cl_re, out_cl_im;

   // Result register
   logic                rsp_vld_ff;
   logic [2*OUT_W-1:0]  rsp_data_ff;
   logic                rsp_sat_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = cle_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= 6'd32;
         pols_ff <= 2'd1;
         step_ff <= 16'd1024;
      end else if (csr_wr) begin
         case (csr_reg)
            REG_TAPS: taps_ff <= csr_pwdata[5:0];
            REG_POLS: pols_ff <= csr_pwdata[1:0];
            REG_STEP: step_ff <= csr_pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_TAPS: csr_prdata = {26'd0, taps_ff};
         REG_POLS: csr_prdata = {30'd0, pols_ff};
         REG_STEP: csr_prdata = {16'd0, step_ff};
         default:  csr_prdata = '0;
      endcase
   end

   assign nt = (taps_ff > 6'(MAX_TAPS)) ? 6'(MAX_TAPS) : taps_ff;
   assign np = (pols_ff > 2'(MAX_POLS)) ? 2'(MAX_POLS) : pols_ff;

   assign req_op     = cle_op_type'(req_tuser[1:0]);
   assign req_acc    = req_tvalid && req_tready;
   assign pipe_busy  = rd_vld_ff || mac_stat.s1_vld || mac_stat.s2_vld || mac_stat.s3_vld;
   assign last_issue = ({1'b0, j_ff} == nt - 6'd1) && ({1'b0, k_ff} == np - 2'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      req_tready = 1'b0;
      issue      = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            j_in       = '0;
            k_in       = '0;
            if (req_tvalid && (req_op == OP_FILTER || req_op == OP_UPDATE)) begin
               state_in = (nt == 6'd0 || np == 2'd0) ? ST_DRAIN : ST_RUN;
            end
         end
         ST_RUN: begin
            issue = 1'b1;
            if (last_issue) begin
               state_in = ST_DRAIN;
            end else if ({1'b0, j_ff} == nt - 6'd1) begin
               j_in = '0;
               k_in = k_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = (op_ff == OP_FILTER) ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff     <= req_op;
         err_re_ff <= req_tdata[52:37];
         err_im_ff <= req_tdata[68:53];
      end
   end

   // Each delay line is a ring; the head points at the newest sample.
   assign push_we  = req_acc && (req_op == OP_PUSH);
   assign head_sel = (state_ff == ST_RUN) ? k_ff : req_tuser[2];
   assign head_cur = head_ff[head_sel];
   assign head_nxt = head_cur + 1'b1;
   assign slot     = TAP_W'(6'(head_cur) + 6'(j_ff) + 6'd1 - nt);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < MAX_POLS; p++) begin
            head_ff[p] <= '0;
         end
         smp_vld_ff <= '0;
      end else if (push_we) begin
         head_ff[req_tuser[2]]              <= head_nxt;
         smp_vld_ff[{req_tuser[2], head_nxt}] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_we) begin
         smp_mem[{req_tuser[2], head_nxt}] <= req_tdata[36:5];
      end
      smp_rd_ff <= smp_mem[{k_ff, slot}];
      smp_ok_ff <= smp_vld_ff[{k_ff, slot}];
   end

   assign wb_we = mac_stat.s3_vld && (op_ff == OP_UPDATE);

   always_comb begin
      tap_we    = wb_we;
      tap_waddr = addr_p_ff[2];
      tap_wdata = {new_im[COEF_W-1:0], new_re[COEF_W-1:0]};
      if (req_acc && req_op == OP_WRTAP) begin
         tap_we    = 1'b1;
         tap_waddr = {req_tuser[2], req_tdata[4:0]};
         tap_wdata = req_tdata[116:69];
      end
      if (wb_we) begin
         tap_wdata = {clip_tap(new_im), clip_tap(new_re)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_vld_ff <= '0;
      end else if (tap_we) begin
         tap_vld_ff[tap_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tap_we) begin
         tap_mem[tap_waddr] <= tap_wdata;
      end
      tap_rd_ff <= tap_mem[{k_ff, j_ff}];
      tap_ok_ff <= tap_vld_ff[{k_ff, j_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff   <= {k_ff, j_ff};
      tap_p_ff[0]  <= tap_eff;
      tap_p_ff[1]  <= tap_p_ff[0];
      tap_p_ff[2]  <= tap_p_ff[1];
      addr_p_ff[0] <= rd_addr_ff;
      addr_p_ff[1] <= addr_p_ff[0];
      addr_p_ff[2] <= addr_p_ff[1];
   end

   assign smp_eff = smp_ok_ff ? smp_rd_ff : '0;
   assign tap_eff = tap_ok_ff ? tap_rd_ff : '0;

   always_comb begin
      if (op_ff == OP_UPDATE) begin
         mac_a_re = COEF_W'($signed(err_re_ff));
         mac_a_im = COEF_W'($signed(err_im_ff));
      end else begin
         mac_a_re = $signed(tap_eff[COEF_W-1:0]);
         mac_a_im = $signed(tap_eff[2*COEF_W-1:COEF_W]);
      end
   end

   assign mac_ctrl.vld = rd_vld_ff;
   assign mac_ctrl.upd = (op_ff == OP_UPDATE);
   assign mac_ctrl.clr = req_acc;

   cle_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .mu     (step_ff),
      .a_re   (mac_a_re),
      .a_im   (mac_a_im),
      .x_re   ($signed(smp_eff[SMP_W-1:0])),
      .x_im   ($signed(smp_eff[2*SMP_W-1:SMP_W])),
      .stat   (mac_stat),
      .acc_re (acc_re),
      .acc_im (acc_im),
      .dlt_re (dlt_re),
      .dlt_im (dlt_im)
   );

   // Tap correction is rounded to Q.20 and subtracted with saturation.
   assign rnd_re = dlt_re + DLT_W'(1 << 27);
   assign rnd_im = dlt_im + DLT_W'(1 << 27);
   assign new_re = 26'($signed(tap_p_ff[2][COEF_W-1:0]))
                   - 26'($signed(rnd_re[DLT_W-1:28]));
   assign new_im = 26'($signed(tap_p_ff[2][2*COEF_W-1:COEF_W]))
                   - 26'($signed(rnd_im[DLT_W-1:28]));

   assign out_rnd_re = acc_re + ACC_W'(1 << 19);
   assign out_rnd_im = acc_im + ACC_W'(1 << 19);
   assign out_cl_re  = clip_out(28'($signed(out_rnd_re[ACC_W-1:20])));
   assign out_cl_im  = clip_out(28'($signed(out_rnd_im[ACC_W-1:20])));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {out_cl_im[OUT_W-1:0], out_cl_re[OUT_W-1:0]};
         rsp_sat_ff  <= out_cl_re[OUT_W] | out_cl_im[OUT_W];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   `ASSERT_IMPL(a_idle_quiet, clock, reset, state_ff == ST_IDLE, !pipe_busy)
   `ASSERT_IMPL(a_s3_busy, clock, reset, mac_stat.s3_vld, state_ff == ST_RUN || state_ff == ST_DRAIN)
   `ASSERT_NEXT(a_done_load, clock, reset, rsp_load, rsp_vld_ff && state_ff == ST_IDLE)

endmodule

// ===== dv/tb_complex_lms_fir_equaliser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex LMS equalizer testbench
// Drives sample pushes, filter requests, LMS updates and tap writes through
// the request stream with random idle gaps and checks every filter output
// against a cycle-free fixed point model of the taps and delay lines. The
// CSR port steps through several tap, polarization and step size settings
// between phases, including the out of range ones.
// ----------------------------------------------------------------------------
module tb_complex_lms_fir_equaliser_top;
   import cle_pkg::*;

   localparam int PHASES           = 9;
   localparam int ITEMS_PER_PHASE  = 200;
   localparam int DRAIN_CYCLES     = 120;
   localparam int HOLD_CYCLES      = 600;
   localparam int HOLD_AFTER       = 30;
   localparam int LIMIT_CYCLES     = 800000;
   localparam int MAX_SHOWN        = 40;

   typedef struct {
      cle_op_type        op;
      logic              pol;
      logic [4:0]        idx;
      logic signed [15:0] s_re;
      logic signed [15:0] s_im;
      logic signed [15:0] e_re;
      logic signed [15:0] e_im;
      logic signed [23:0] t_re;
      logic signed [23:0] t_im;
      bit                wait_empty;
   } eq_item_type;

   typedef struct {
      logic signed [19:0] re;
      logic signed [19:0] im;
      logic               sat;
   } eq_out_type;

   logic          clock;
   logic          reset       = 1'b1;
   logic          req_tvalid  = 1'b0;
   logic          req_tready;
   logic [119:0]  req_tdata   = '0;
   logic [2:0]    req_tuser   = '0;
   logic          rsp_tvalid;
   logic          rsp_tready  = 1'b0;
   logic [39:0]   rsp_tdata;
   logic          rsp_tuser;
   logic          csr_psel    = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite  = 1'b0;
   logic [3:0]    csr_paddr   = '0;
   logic [31:0]   csr_pwdata  = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   complex_lms_fir_equaliser_top dut (.*);

   // Model state: delay lines are newest first, taps are indexed oldest first.
   logic signed [15:0] win_re [MAX_POLS][MAX_TAPS];
   logic signed [15:0] win_im [MAX_POLS][MAX_TAPS];
   logic signed [23:0] coef_re [MAX_POLS][MAX_TAPS];
   logic signed [23:0] coef_im [MAX_POLS][MAX_TAPS];
   logic [5:0]         cfg_taps = 6'd32;
   logic [1:0]         cfg_pols = 2'd1;
   logic [15:0]        cfg_step = 16'd1024;

   eq_item_type pending_items [$];
   eq_out_type  expected_outputs [$];
   eq_item_type cur_item;
   eq_out_type  mon_want;
   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned mismatches     = 0;
   int unsigned req_gap        = 0;
   int unsigned rsp_wait       = 0;
   int unsigned hold_left      = 0;
   int unsigned rsp_seen       = 0;
   int unsigned cycle_count    = 0;
   bit          hold_done      = 0;
   bit          quiet          = 0;
   int          phase;
   int          n;
   eq_item_type rnd_item;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      for (int k = 0; k < MAX_POLS; k++) begin
         for (int j = 0; j < MAX_TAPS; j++) begin
            win_re[k][j]  = '0;
            win_im[k][j]  = '0;
            coef_re[k][j] = '0;
            coef_im[k][j] = '0;
         end
      end
   end

   function automatic longint clip_to(longint v, int w, inout bit hit);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         hit = 1;
         return hi;
      end
      if (v < lo) begin
         hit = 1;
         return lo;
      end
      return v;
   endfunction

   task automatic equalise_item(eq_item_type it);
      int         nt;
      int         np;
      longint     acc_re;
      longint     acc_im;
      longint     xr;
      longint     xi;
      longint     tr;
      longint     ti;
      longint     pr;
      longint     pi;
      longint     dr;
      longint     di;
      bit         hit;
      eq_out_type res;
      nt = (cfg_taps > MAX_TAPS) ? MAX_TAPS : int'(cfg_taps);
      np = (cfg_pols > MAX_POLS) ? MAX_POLS : int'(cfg_pols);
      case (it.op)
         OP_PUSH: begin
            for (int j = MAX_TAPS - 1; j > 0; j--) begin
               win_re[it.pol][j] = win_re[it.pol][j-1];
               win_im[it.pol][j] = win_im[it.pol][j-1];
            end
            win_re[it.pol][0] = it.s_re;
            win_im[it.pol][0] = it.s_im;
         end
         OP_WRTAP: begin
            coef_re[it.pol][it.idx] = it.t_re;
            coef_im[it.pol][it.idx] = it.t_im;
         end
         OP_FILTER: begin
            acc_re = 0;
            acc_im = 0;
            hit    = 0;
            for (int k = 0; k < np; k++) begin
               for (int j = 0; j < nt; j++) begin
                  tr = coef_re[k][j];
                  ti = coef_im[k][j];
                  xr = win_re[k][nt-1-j];
                  xi = win_im[k][nt-1-j];
                  acc_re += tr * xr - ti * xi;
                  acc_im += tr * xi + ti * xr;
               end
            end
            res.re  = 20'(clip_to((acc_re + (longint'(1) <<< 19)) >>> 20, 20, hit));
            res.im  = 20'(clip_to((acc_im + (longint'(1) <<< 19)) >>> 20, 20, hit));
            res.sat = hit;
            expected_outputs.push_back(res);
         end
         default: begin
            for (int k = 0; k < np; k++) begin
               for (int j = 0; j < nt; j++) begin
                  xr = win_re[k][nt-1-j];
                  xi = win_im[k][nt-1-j];
                  pr = longint'(it.e_re) * xr + longint'(it.e_im) * xi;
                  pi = longint'(it.e_im) * xr - longint'(it.e_re) * xi;
                  dr = (longint'(cfg_step) * pr + (longint'(1) <<< 27)) >>> 28;
                  di = (longint'(cfg_step) * pi + (longint'(1) <<< 27)) >>> 28;
                  hit = 0;
                  coef_re[k][j] = 24'(clip_to(longint'(coef_re[k][j]) - dr, 24, hit));
                  coef_im[k][j] = 24'(clip_to(longint'(coef_im[k][j]) - di, 24, hit));
               end
            end
         end
      endcase
   endtask

   function automatic int unsigned draw_idle();
      return quiet ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic logic signed [15:0] pick_s16();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom);
         1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return 16'($urandom_range(0, 8191) - 4096);
      endcase
   endfunction

   function automatic logic signed [23:0] pick_s24();
      case ($urandom_range(0, 3))
         0:       return 24'($urandom);
         1:       return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
         default: return 24'($urandom_range(0, 2097151) - 1048576);
      endcase
   endfunction

   function automatic eq_item_type random_item();
      eq_item_type it;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      it.op   = (roll < 40) ? OP_PUSH : (roll < 65) ? OP_FILTER :
                (roll < 85) ? OP_UPDATE : OP_WRTAP;
      it.pol  = 1'($urandom_range(0, 1));
      it.idx  = 5'($urandom_range(0, MAX_TAPS - 1));
      it.s_re = pick_s16();
      it.s_im = pick_s16();
      it.e_re = pick_s16();
      it.e_im = pick_s16();
      it.t_re = pick_s24();
      it.t_im = pick_s24();
      it.wait_empty = 0;
      return it;
   endfunction

   // The same pair of values lands in the sample, error and tap fields.
   function automatic eq_item_type make_item(cle_op_type op, bit pol, int idx, int a, int b);
      eq_item_type it;
      it.op   = op;
      it.pol  = pol;
      it.idx  = idx[4:0];
      it.s_re = a[15:0];
      it.s_im = b[15:0];
      it.e_re = a[15:0];
      it.e_im = b[15:0];
      it.t_re = a[23:0];
      it.t_im = b[23:0];
      it.wait_empty = 0;
      return it;
   endfunction

   task automatic queue_item(eq_item_type it);
      pending_items.push_back(it);
      queued_count++;
   endtask

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endtask

   task automatic csr_write(cle_reg_type r, logic [31:0] v);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (r)
         REG_TAPS: cfg_taps = v[5:0];
         REG_POLS: cfg_pols = v[1:0];
         default:  cfg_step = v[15:0];
      endcase
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (accepted_count != queued_count || expected_outputs.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            equalise_item(cur_item);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].wait_empty && expected_outputs.size() != 0)) begin
               cur_item = pending_items.pop_front();
               req_tdata <= {3'b000, cur_item.t_im, cur_item.t_re, cur_item.e_im,
                             cur_item.e_re, cur_item.s_im, cur_item.s_re, cur_item.idx};
               req_tuser <= {cur_item.pol, cur_item.op};
               req_tvalid <= 1'b1;
               req_gap = draw_idle();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outputs.size() == 0) begin
               report_mismatch("filter output with no request waiting");
            end else begin
               mon_want = expected_outputs.pop_front();
               if (rsp_tdata[19:0] !== mon_want.re)
                  report_mismatch($sformatf("out_re got %0d want %0d",
                                            $signed(rsp_tdata[19:0]), mon_want.re));
               if (rsp_tdata[39:20] !== mon_want.im)
                  report_mismatch($sformatf("out_im got %0d want %0d",
                                            $signed(rsp_tdata[39:20]), mon_want.im));
               if (rsp_tuser !== mon_want.sat)
                  report_mismatch($sformatf("saturated got %b want %b",
                                            rsp_tuser, mon_want.sat));
            end
            rsp_wait = draw_idle();
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_tready <= (rsp_wait == 0) && (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 0;
         rsp_seen  <= 0;
      end else begin
         rsp_seen <= rsp_seen + ((rsp_tvalid && rsp_tready) ? 1 : 0);
         if (!hold_done && rsp_seen == HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: ;
            1: begin
               csr_write(REG_TAPS, 32'd1);
               csr_write(REG_POLS, 32'd1);
               csr_write(REG_STEP, 32'd0);
            end
            2: begin
               csr_write(REG_TAPS, 32'd32);
               csr_write(REG_POLS, 32'd2);
               csr_write(REG_STEP, 32'd65535);
            end
            3: begin
               csr_write(REG_TAPS, 32'd0);
               csr_write(REG_POLS, 32'd0);
               csr_write(REG_STEP, $urandom_range(0, 65535));
            end
            4: begin
               csr_write(REG_TAPS, 32'd63);
               csr_write(REG_POLS, 32'd3);
               csr_write(REG_STEP, $urandom_range(0, 65535));
            end
            default: begin
               csr_write(REG_TAPS, $urandom_range(1, MAX_TAPS));
               csr_write(REG_POLS, $urandom_range(1, MAX_POLS));
               csr_write(REG_STEP, $urandom_range(0, 65535));
            end
         endcase
         quiet = (phase % 3 == 2);
         if (phase == 0) begin
            queue_item(make_item(OP_FILTER, 0, 0, 0, 0));
            queue_item(make_item(OP_WRTAP, 0, 0, 8388607, -8388608));
            queue_item(make_item(OP_WRTAP, 1, 31, -8388608, 8388607));
            queue_item(make_item(OP_WRTAP, 0, 31, 8388607, 8388607));
            queue_item(make_item(OP_WRTAP, 0, 30, 8388607, 8388607));
            queue_item(make_item(OP_WRTAP, 0, 29, 8388607, 8388607));
            repeat (3) queue_item(make_item(OP_PUSH, 0, 0, 32767, 32767));
            queue_item(make_item(OP_PUSH, 1, 0, -32768, -32768));
            queue_item(make_item(OP_FILTER, 0, 0, 0, 0));
            queue_item(make_item(OP_UPDATE, 0, 0, 32767, -32768));
            queue_item(make_item(OP_FILTER, 1, 31, 0, 0));
            queue_item(make_item(OP_PUSH, 0, 0, -32768, 32767));
            queue_item(make_item(OP_UPDATE, 1, 0, -32768, 32767));
            queue_item(make_item(OP_FILTER, 0, 0, 0, 0));
            queue_item(make_item(OP_PUSH, 0, 0, 0, 0));
            queue_item(make_item(OP_WRTAP, 1, 0, 1 << 20, 0));
            queue_item(make_item(OP_FILTER, 0, 0, 0, 0));
            queue_item(make_item(OP_UPDATE, 0, 0, 0, 0));
            queue_item(make_item(OP_FILTER, 0, 0, 0, 0));
         end
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            rnd_item = random_item();
            rnd_item.wait_empty = (n == ITEMS_PER_PHASE / 2);
            queue_item(rnd_item);
         end
         wait_idle();
      end
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cle_pkg.sv
rtl/cle_mac.sv
rtl/complex_lms_fir_equaliser_top.sv
dv/tb_complex_lms_fir_equaliser_top.sv
